// ----- hdl/mclc_pkg.sv -----
// Shared types and constants for the multi-channel life countdown.
// Holds command codes, register indexes and the hours conversion constants.
// No dependencies.
package mclc_pkg;

  // Command codes carried by the command field of an input word.
  typedef enum logic [2:0] {
    CMD_ELAPSE      = 3'd0,
    CMD_QUERY       = 3'd1,
    CMD_RESET_ONE   = 3'd2,
    CMD_RESET_ALL   = 3'd3,
    CMD_SAVE_CHECK  = 3'd4,
    CMD_RESTORE     = 3'd5
  } cmd_t;

  // Configuration register indexes: totals occupy 0 to SLOT_COUNT-1.
  localparam int SLOT_COUNT = 4;
  localparam logic [2:0] REG_SAVE_INTERVAL = 3'd4;

  localparam logic [31:0] DEFAULT_SAVE_INTERVAL = 32'd12000;
  localparam logic [31:0] HOUR_SECONDS          = 32'd3600;
  localparam logic [15:0] HOURS_MAX             = 16'hFFFF;

  // Largest count whose rounded-up hours still fit below saturation.
  localparam logic [31:0] HOURS_SAT_SECONDS = 32'd235926000;

  // Rounding bias so that a floor division gives the ceiling.
  localparam logic [27:0] HOUR_ROUND_BIAS = 28'd3599;

  // 3600 = 16 * 225. After a shift by 4, divide by 225 with a reciprocal:
  // ceil(2^32 / 225), exact for every 24-bit dividend.
  localparam logic [24:0] RECIP_225 = 25'd19088744;

endpackage

// ----- hdl/multi_channel_life_countdown.sv -----
// Top level of the multi-channel life countdown.
// Depends on mclc_pkg for command codes and conversion constants.
//
// Usage:
// A command word (command, amount_seconds, filter_index, now_seconds) is taken
// at a rising clock edge where start is high and busy is low. Busy stays low,
// so a new word can be issued in every cycle. Each word gives exactly one
// result word (remaining_seconds, remaining_hours, save_request, any_expired),
// shown for one cycle with done high.
// The channel counts, save marks and the selected count are registered when
// the word is accepted, and the hours conversion (one reciprocal multiply) is
// then registered in the result register. Throughput is one word per cycle;
// each word sees the state left by the word before it.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data at
// any edge where cfg_wr_en is high; indexes 0 to 3 are the channel totals,
// index 4 the save interval, and other indexes are ignored.
// Synchronous reset clears all counts, marks and the last save time, sets the
// totals to zero and the save interval to 12000 seconds. The receiver cannot
// stall; a result is present for one cycle only.
module multi_channel_life_countdown
  import mclc_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] amount_seconds,
  input  logic [1:0]  filter_index,
  input  logic [31:0] now_seconds,
  output logic        done,
  output logic [31:0] remaining_seconds,
  output logic [15:0] remaining_hours,
  output logic        save_request,
  output logic        any_expired,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wr_data
);

  // Configuration registers.
  logic [31:0] total_time [SLOT_COUNT];
  logic [31:0] save_interval;

  // Block state.
  logic [31:0] remaining_life [CHANNEL_COUNT];
  logic        save_pending;
  logic        save_urgent;
  logic [31:0] last_save_time;

  // Next-state values.
  logic [31:0] remaining_life_next [CHANNEL_COUNT];
  logic        save_pending_next;
  logic        save_urgent_next;
  logic [31:0] last_save_time_next;
  logic        req_next;
  logic        expired_next;
  logic [31:0] sec_next;

  // First result stage.
  logic        stage_valid;
  logic [31:0] stage_sec;
  logic        stage_req;
  logic        stage_expired;

  // Hours conversion path.
  logic        accept;
  logic [27:0] hours_biased;
  logic [23:0] hours_dividend;
  logic [48:0] hours_product;
  logic [15:0] hours_value;
  logic [31:0] elapsed;

  // Every word is taken as soon as it is offered.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        total_time[i] <= '0;
      end
      save_interval <= DEFAULT_SAVE_INTERVAL;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SAVE_INTERVAL) begin
        save_interval <= cfg_wr_data;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cfg_index == 3'(i)) begin
          total_time[i] <= cfg_wr_data;
        end
      end
    end
  end

  assign elapsed = now_seconds - last_save_time;

  // Command decode and state update for one word.
  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      remaining_life_next[i] = remaining_life[i];
    end
    save_pending_next   = save_pending;
    save_urgent_next    = save_urgent;
    last_save_time_next = last_save_time;
    req_next            = 1'b0;
    expired_next        = 1'b0;
    sec_next            = '0;

    case (command)
      CMD_ELAPSE: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (remaining_life[i] > amount_seconds) begin
            remaining_life_next[i] = remaining_life[i] - amount_seconds;
          end else begin
            if (remaining_life[i] != '0) begin
              save_urgent_next = 1'b1;
            end
            remaining_life_next[i] = '0;
          end
        end
        save_pending_next = 1'b1;
      end
      CMD_RESET_ONE: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (filter_index == 2'(i)) begin
            remaining_life_next[i] = total_time[i];
          end
        end
        req_next = 1'b1;
      end
      CMD_RESET_ALL: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          remaining_life_next[i] = total_time[i];
        end
        req_next = 1'b1;
      end
      CMD_SAVE_CHECK: begin
        if (((elapsed >= save_interval) && save_pending) || save_urgent) begin
          req_next            = 1'b1;
          last_save_time_next = now_seconds;
          save_pending_next   = 1'b0;
          save_urgent_next    = 1'b0;
        end
      end
      CMD_RESTORE: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (filter_index == 2'(i)) begin
            remaining_life_next[i] = amount_seconds;
          end
        end
      end
      default: begin
      end
    endcase

    // Expiry scan and selection of the reported channel.
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (remaining_life_next[i] == '0) begin
        expired_next = 1'b1;
      end
      if (filter_index == 2'(i)) begin
        sec_next = remaining_life_next[i];
      end
    end
  end

  // State registers and the first result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        remaining_life[i] <= '0;
      end
      save_pending   <= 1'b0;
      save_urgent    <= 1'b0;
      last_save_time <= '0;
      stage_valid    <= 1'b0;
    end else begin
      stage_valid <= accept;
      if (accept) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          remaining_life[i] <= remaining_life_next[i];
        end
        save_pending   <= save_pending_next;
        save_urgent    <= save_urgent_next;
        last_save_time <= last_save_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_sec     <= sec_next;
      stage_req     <= req_next;
      stage_expired <= expired_next;
    end
  end

  // Hours rounded up: (sec + 3599) / 3600 as a shift and a reciprocal multiply.
  assign hours_biased   = stage_sec[27:0] + HOUR_ROUND_BIAS;
  assign hours_dividend = hours_biased[27:4];
  assign hours_product  = {25'd0, hours_dividend} * {24'd0, RECIP_225};
  assign hours_value    = (stage_sec > HOURS_SAT_SECONDS) ? HOURS_MAX
                                                          : hours_product[47:32];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      remaining_seconds <= stage_sec;
      remaining_hours   <= hours_value;
      save_request      <= stage_req;
      any_expired       <= stage_expired;
    end
  end

  // Every accepted word produces a result, passed on through stage_valid to done.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted word produced no result");

  // Hours are the rounded-up quotient whenever the seconds are at most HOURS_SAT_SECONDS.
  a_hours_exact: assert property (@(posedge clk) disable iff (rst)
    (done && (remaining_seconds <= HOURS_SAT_SECONDS)) |->
      ((32'(remaining_hours) * HOUR_SECONDS >= remaining_seconds) &&
       (32'(remaining_hours) * HOUR_SECONDS < remaining_seconds + HOUR_SECONDS)))
    else $error("hours conversion is wrong");

  // An elapse word always leaves a pending save behind.
  a_elapse_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_ELAPSE)) |=> save_pending)
    else $error("elapse did not set the pending save mark");

endmodule
